### hw/rtl/aim_angle_atan2_defines.svh
// ----------------------------------------------------------------------------
// aim_angle_atan2 assertion macros
// Shared concurrent checks, clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef AIM_ANGLE_ATAN2_DEFINES_SVH
`define AIM_ANGLE_ATAN2_DEFINES_SVH

// same-cycle implication
`define AIM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("aim_angle_atan2: same-cycle check failed");

// next-cycle implication
`define AIM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("aim_angle_atan2: next-cycle check failed");

`endif

### hw/rtl/aim_pkg.sv
// ----------------------------------------------------------------------------
// aim_pkg
// Widths, angle constants and the arctangent table for the bearing pipeline.
// ----------------------------------------------------------------------------
package aim_pkg;

    localparam int COORD_W    = 20;
    localparam int DIFF_W     = 21;
    localparam int PRE_SCALE  = 20;
    localparam int VEC_W      = 43;
    localparam int ANG_W      = 34;
    localparam int BEAR_W     = 16;
    localparam int TABLE_SIZE = 24;
    localparam int ROUND_SHIFT = 17;

    localparam logic signed [BEAR_W-1:0] PI_Q13      = 16'sd25736;
    localparam logic signed [BEAR_W-1:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [BEAR_W-1:0] BEAR_MIN    = -16'sd25735;
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0]  ROUND_HALF  = 34'sd65536;

    localparam logic [31:0] ATAN_Q30 [TABLE_SIZE] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    typedef struct packed {
        logic signed [VEC_W-1:0]  x;
        logic signed [VEC_W-1:0]  y;
        logic signed [ANG_W-1:0]  z;
        logic                     spec;
        logic signed [BEAR_W-1:0] spec_val;
    } aim_vec_t;

endpackage

### hw/rtl/aim_pre.sv
// ----------------------------------------------------------------------------
// aim_pre
// Offset subtraction with special-case detection, then scaling and the
// quarter-turn pre-rotation into the right half plane. Two register stages.
// ----------------------------------------------------------------------------
module aim_pre (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [aim_pkg::COORD_W-1:0]  target_x,
    input  logic signed [aim_pkg::COORD_W-1:0]  target_y,
    input  logic signed [aim_pkg::COORD_W-1:0]  origin_x,
    input  logic signed [aim_pkg::COORD_W-1:0]  origin_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output aim_pkg::aim_vec_t                   out_vec
);

    localparam int EXT_W = aim_pkg::VEC_W - aim_pkg::DIFF_W - aim_pkg::PRE_SCALE;

    logic                                   a_valid_reg;
    logic signed [aim_pkg::DIFF_W-1:0]      dx_reg, dx_next;
    logic signed [aim_pkg::DIFF_W-1:0]      dy_reg, dy_next;
    logic                                   spec_reg, spec_next;
    logic signed [aim_pkg::BEAR_W-1:0]      sval_reg, sval_next;
    logic                                   a_ready;

    logic                                   b_valid_reg;
    aim_pkg::aim_vec_t                      vec_reg, vec_next;
    logic signed [aim_pkg::VEC_W-1:0]       xs, ys;

    assign a_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_comb begin
        dx_next = {target_x[aim_pkg::COORD_W-1], target_x}
                - {origin_x[aim_pkg::COORD_W-1], origin_x};
        dy_next = {target_y[aim_pkg::COORD_W-1], target_y}
                - {origin_y[aim_pkg::COORD_W-1], origin_y};
        spec_next = 1'b0;
        sval_next = '0;
        if (dx_next == '0) begin
            spec_next = 1'b1;
            sval_next = (dy_next > 0) ? aim_pkg::HALF_PI_Q13 : -aim_pkg::HALF_PI_Q13;
        end else if (dy_next == '0) begin
            spec_next = 1'b1;
            sval_next = (dx_next > 0) ? '0 : aim_pkg::PI_Q13;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            spec_reg <= spec_next;
            sval_reg <= sval_next;
        end
    end

    always_comb begin
        xs = {{EXT_W{dx_reg[aim_pkg::DIFF_W-1]}}, dx_reg, {aim_pkg::PRE_SCALE{1'b0}}};
        ys = {{EXT_W{dy_reg[aim_pkg::DIFF_W-1]}}, dy_reg, {aim_pkg::PRE_SCALE{1'b0}}};
        vec_next.spec     = spec_reg;
        vec_next.spec_val = sval_reg;
        vec_next.x        = xs;
        vec_next.y        = ys;
        vec_next.z        = '0;
        if (xs < 0) begin
            if (ys > 0) begin
                vec_next.x = ys;
                vec_next.y = -xs;
                vec_next.z = aim_pkg::HALF_PI_Q30;
            end else begin
                vec_next.x = -ys;
                vec_next.y = xs;
                vec_next.z = -aim_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (a_valid_reg && a_ready) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_vec   = vec_reg;

endmodule

### hw/rtl/aim_stage.sv
// ----------------------------------------------------------------------------
// aim_stage
// One registered CORDIC vectoring iteration: drive y toward zero by a shift
// of STAGE_IDX and accumulate the matching arctangent.
// ----------------------------------------------------------------------------
module aim_stage #(
    parameter int STAGE_IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  aim_pkg::aim_vec_t in_vec,
    output logic              out_valid,
    input  logic              out_ready,
    output aim_pkg::aim_vec_t out_vec
);

    localparam logic signed [aim_pkg::ANG_W-1:0] ANGLE =
        {2'b00, aim_pkg::ATAN_Q30[STAGE_IDX]};

    logic              valid_reg;
    aim_pkg::aim_vec_t vec_reg, vec_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        vec_next = in_vec;
        if (in_vec.y < 0) begin
            vec_next.x = in_vec.x - (in_vec.y >>> STAGE_IDX);
            vec_next.y = in_vec.y + (in_vec.x >>> STAGE_IDX);
            vec_next.z = in_vec.z - ANGLE;
        end else begin
            vec_next.x = in_vec.x + (in_vec.y >>> STAGE_IDX);
            vec_next.y = in_vec.y - (in_vec.x >>> STAGE_IDX);
            vec_next.z = in_vec.z + ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

### hw/rtl/aim_post.sv
// ----------------------------------------------------------------------------
// aim_post
// Round the accumulated angle to Q3.13, fold the ends into (-pi, pi] and
// select the special-case bearing. Output register of the block.
// ----------------------------------------------------------------------------
module aim_post (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  aim_pkg::aim_vec_t                  in_vec,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [aim_pkg::BEAR_W-1:0]  bearing
);

    localparam int R_W = aim_pkg::ANG_W - aim_pkg::ROUND_SHIFT;

    logic                              valid_reg;
    logic signed [aim_pkg::BEAR_W-1:0] bear_reg, bear_next;
    logic signed [aim_pkg::ANG_W-1:0]  zr;
    logic signed [R_W-1:0]             r;
    logic signed [R_W-1:0]             pi_ext, neg_pi_ext;

    assign in_ready   = !valid_reg || out_ready;
    assign pi_ext     = R_W'(aim_pkg::PI_Q13);
    assign neg_pi_ext = -pi_ext;

    always_comb begin
        zr = in_vec.z + aim_pkg::ROUND_HALF;
        r  = zr[aim_pkg::ANG_W-1:aim_pkg::ROUND_SHIFT];
        if (in_vec.spec) begin
            bear_next = in_vec.spec_val;
        end else if (r > pi_ext || r <= neg_pi_ext) begin
            bear_next = aim_pkg::PI_Q13;
        end else begin
            bear_next = r[aim_pkg::BEAR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            bear_reg <= bear_next;
        end
    end

    assign out_valid = valid_reg;
    assign bearing   = bear_reg;

endmodule

### hw/rtl/aim_angle_atan2.sv
// ----------------------------------------------------------------------------
// aim_angle_atan2
// Bearing from an own point to a target point, atan2 style, by a pipelined
// CORDIC in vectoring mode.
//
// s_ channel: one beat carries target x/y and own x/y, signed Q16.4.
// m_ channel: one beat per input beat, the bearing in signed Q3.13 radians,
// range (-pi, pi]; beats leave in the order they arrived.
// RUN_STAGES is ROTATION_STAGES capped at the 24-entry arctangent table.
// Registers in order: subtraction, pre-rotation, one per CORDIC
// iteration, then rounding.
// Throughput: one beat per cycle unless stalled; every stage holds one beat
// and its own valid bit, so bubbles close up while the receiver stalls.
// When m_tready is low, beats keep entering until each stage is full, then
// s_tready falls; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties all stages; no clearing pass.
// ----------------------------------------------------------------------------
`include "aim_angle_atan2_defines.svh"

module aim_angle_atan2 #(
    parameter int ROTATION_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // target_x, target_y, origin_x, origin_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // bearing
);

    localparam int CW = aim_pkg::COORD_W;
    localparam int RUN_STAGES = (ROTATION_STAGES > aim_pkg::TABLE_SIZE) ?
                                aim_pkg::TABLE_SIZE : ROTATION_STAGES;

    logic                  vld [RUN_STAGES+1];
    logic                  rdy [RUN_STAGES+1];
    aim_pkg::aim_vec_t     vec [RUN_STAGES+1];
    logic signed [aim_pkg::BEAR_W-1:0] bearing;

    aim_pre u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .target_x  (s_tdata[CW-1:0]),
        .target_y  (s_tdata[2*CW-1:CW]),
        .origin_x  (s_tdata[3*CW-1:2*CW]),
        .origin_y  (s_tdata[4*CW-1:3*CW]),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_vec   (vec[0])
    );

    for (genvar i = 0; i < RUN_STAGES; i++) begin : g_stage
        aim_stage #(
            .STAGE_IDX (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_vec    (vec[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_vec   (vec[i+1])
        );
    end

    aim_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[RUN_STAGES]),
        .in_ready  (rdy[RUN_STAGES]),
        .in_vec    (vec[RUN_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .bearing   (bearing)
    );

    assign m_tdata = bearing;

    `AIM_ASSERT_NOW(a_bearing_range, m_tvalid,
        $signed(m_tdata) <= aim_pkg::PI_Q13 && $signed(m_tdata) >= aim_pkg::BEAR_MIN)
    `AIM_ASSERT_NOW(a_ready_flows, m_tready, s_tready)
    `AIM_ASSERT_NEXT(a_out_drains, m_tvalid && m_tready && !vld[RUN_STAGES],
        !m_tvalid)

endmodule
